// ===== design/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

   localparam int TEXT_COLUMNS = 80;
   localparam int TEXT_ROWS    = 25;

   localparam logic [8:0] COL_LIMIT = 9'(TEXT_COLUMNS);
   localparam logic [7:0] ROW_LIMIT = 8'(TEXT_ROWS);
   localparam logic [6:0] ROW_LAST  = 7'(TEXT_ROWS - 1);

   localparam logic [6:0]  ATTR_RESET  = 7'h07;
   localparam logic [15:0] CH_BACK     = 16'h0008;
   localparam logic [15:0] CH_TAB      = 16'h0009;
   localparam logic [15:0] CH_LF       = 16'h000a;
   localparam logic [15:0] CH_CR       = 16'h000d;
   localparam logic [7:0]  GLYPH_SPACE = 8'h20;
   localparam logic [7:0]  GLYPH_ALT   = 8'h3f;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      CMD_CELL   = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_FILL   = 2'd2,
      CMD_DONE   = 2'd3
   } rsp_cmd_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_HOME_COL,
      CUR_LINE_DOWN,
      CUR_BACK,
      CUR_SET,
      CUR_HOME,
      CUR_ADVANCE
   } cur_op_type;

   typedef struct packed {
      logic        load;
      cur_op_type  cur_op;
      logic        emit;
      rsp_cmd_type kind;
   } tcce_cmd_type;

   typedef struct packed {
      req_op_type op;
      logic       is_cr;
      logic       is_lf;
      logic       is_back;
      logic       is_tab;
      logic       is_print;
      logic       set_ok;
      logic       row_last;
      logic       wrap;
      logic       tab_more;
      logic       out_free;
   } tcce_status_type;

   function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
      logic [23:0] rgb;
      unique case (idx)
         4'd0:    rgb = 24'h000000;
         4'd1:    rgb = 24'h0000aa;
         4'd2:    rgb = 24'h00aa00;
         4'd3:    rgb = 24'h00aaaa;
         4'd4:    rgb = 24'haa0000;
         4'd5:    rgb = 24'haa00aa;
         4'd6:    rgb = 24'haa5500;
         4'd7:    rgb = 24'haaaaaa;
         4'd8:    rgb = 24'h555555;
         4'd9:    rgb = 24'h5555ff;
         4'd10:   rgb = 24'h55ff55;
         4'd11:   rgb = 24'h55ffff;
         4'd12:   rgb = 24'hff5555;
         4'd13:   rgb = 24'hff55ff;
         4'd14:   rgb = 24'hffff55;
         default: rgb = 24'hffffff;
      endcase
      return rgb;
   endfunction

endpackage

// ===== design/tcce_ctrl.sv =====
`timescale 1ns / 1ps

module tcce_ctrl
   import tcce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  tcce_status_type status,
   output tcce_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_CELL   = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.cur_op = CUR_HOLD;
      cmd.emit   = 1'b0;
      cmd.kind   = CMD_DONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            unique case (status.op)
               OP_PUT: begin
                  if (status.is_cr) begin
                     cmd.cur_op = CUR_HOME_COL;
                  end else if (status.is_lf) begin
                     if (status.row_last) begin
                        state_in = ST_SCROLL;
                     end else begin
                        cmd.cur_op = CUR_LINE_DOWN;
                     end
                  end else if (status.is_back) begin
                     cmd.cur_op = CUR_BACK;
                  end else if (status.is_tab || status.is_print) begin
                     state_in = ST_CELL;
                  end
               end
               OP_SET:   cmd.cur_op = CUR_SET;
               OP_CLEAR: state_in = ST_FILL;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_CELL: begin
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.kind   = CMD_CELL;
               cmd.cur_op = CUR_ADVANCE;
               if (status.wrap) begin
                  state_in = status.row_last ? ST_SCROLL : ST_DONE;
               end else if (status.is_tab && status.tab_more) begin
                  state_in = ST_CELL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCROLL: begin
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.kind   = CMD_SCROLL;
               cmd.cur_op = CUR_HOME_COL;
               state_in   = ST_DONE;
            end
         end
         ST_FILL: begin
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.kind   = CMD_FILL;
               cmd.cur_op = CUR_HOME;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = CMD_DONE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/tcce_datapath.sv =====
`timescale 1ns / 1ps

module tcce_datapath
   import tcce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [6:0]      csr_wr_data,
   input  logic [1:0]      req_operation,
   input  logic [15:0]     req_character,
   input  logic [7:0]      req_target_column,
   input  logic [6:0]      req_target_row,
   input  tcce_cmd_type    cmd,
   output tcce_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_command,
   output logic [7:0]      rsp_cell_column,
   output logic [6:0]      rsp_cell_row,
   output logic [7:0]      rsp_glyph,
   output logic [23:0]     rsp_fore_color,
   output logic [23:0]     rsp_back_color,
   output logic            rsp_accepted,
   output logic [7:0]      rsp_cursor_col_now,
   output logic [6:0]      rsp_cursor_row_now,
   output logic            rsp_last
);

   logic [6:0]  attr_ff, attr_in;
   logic [7:0]  col_ff, col_in;
   logic [6:0]  row_ff, row_in;
   logic        acc_ff, acc_in;
   req_op_type  op_ff, op_in;
   logic [15:0] char_ff, char_in;
   logic [7:0]  tcol_ff, tcol_in;
   logic [6:0]  trow_ff, trow_in;

   logic        valid_ff, valid_in;
   rsp_cmd_type kind_ff, kind_in;
   logic [7:0]  ccol_ff, ccol_in;
   logic [6:0]  crow_ff, crow_in;
   logic [7:0]  glyph_ff, glyph_in;
   logic [23:0] fore_ff, fore_in;
   logic [23:0] back_ff, back_in;
   logic        racc_ff, racc_in;
   logic [7:0]  ncol_ff, ncol_in;
   logic [6:0]  nrow_ff, nrow_in;
   logic        last_ff, last_in;

   logic [8:0]  col_next;
   logic [7:0]  cell_glyph;
   logic [23:0] fg_rgb;
   logic [23:0] bg_rgb;

   assign col_next   = {1'b0, col_ff} + 9'd1;
   assign fg_rgb     = palette_rgb(attr_ff[3:0]);
   assign bg_rgb     = palette_rgb({1'b0, attr_ff[6:4]});
   assign cell_glyph = (char_ff == CH_TAB) ? GLYPH_SPACE :
                       (char_ff[15:8] == 8'd0) ? char_ff[7:0] : GLYPH_ALT;

   assign status.op       = op_ff;
   assign status.is_cr    = (char_ff == CH_CR);
   assign status.is_lf    = (char_ff == CH_LF);
   assign status.is_back  = (char_ff == CH_BACK);
   assign status.is_tab   = (char_ff == CH_TAB);
   assign status.is_print = (char_ff[15:5] != 11'd0);
   assign status.set_ok   = ({1'b0, tcol_ff} < COL_LIMIT) && ({1'b0, trow_ff} < ROW_LIMIT);
   assign status.row_last = (row_ff == ROW_LAST);
   assign status.wrap     = (col_next == COL_LIMIT);
   assign status.tab_more = (col_next[2:0] != 3'd0);
   assign status.out_free = !valid_ff || !rsp_stall;

   always_comb begin
      attr_in = csr_wr_en ? csr_wr_data : attr_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      acc_in  = acc_ff;
      op_in   = op_ff;
      char_in = char_ff;
      tcol_in = tcol_ff;
      trow_in = trow_ff;
      if (cmd.load) begin
         op_in   = req_op_type'(req_operation);
         char_in = req_character;
         tcol_in = req_target_column;
         trow_in = req_target_row;
         acc_in  = 1'b1;
      end
      unique case (cmd.cur_op)
         CUR_HOLD: ;
         CUR_HOME_COL: col_in = 8'd0;
         CUR_LINE_DOWN: begin
            col_in = 8'd0;
            row_in = row_ff + 7'd1;
         end
         CUR_BACK: begin
            if (col_ff != 8'd0) begin
               col_in = col_ff - 8'd1;
            end
         end
         CUR_SET: begin
            if (status.set_ok) begin
               col_in = tcol_ff;
               row_in = trow_ff;
            end else begin
               acc_in = 1'b0;
            end
         end
         CUR_HOME: begin
            col_in = 8'd0;
            row_in = 7'd0;
         end
         CUR_ADVANCE: begin
            if (status.wrap) begin
               col_in = 8'd0;
               if (!status.row_last) begin
                  row_in = row_ff + 7'd1;
               end
            end else begin
               col_in = col_next[7:0];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      kind_in  = kind_ff;
      ccol_in  = ccol_ff;
      crow_in  = crow_ff;
      glyph_in = glyph_ff;
      fore_in  = fore_ff;
      back_in  = back_ff;
      racc_in  = racc_ff;
      ncol_in  = ncol_ff;
      nrow_in  = nrow_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cmd.kind;
         ccol_in  = 8'd0;
         crow_in  = 7'd0;
         glyph_in = 8'd0;
         fore_in  = 24'd0;
         back_in  = bg_rgb;
         racc_in  = 1'b1;
         ncol_in  = 8'd0;
         nrow_in  = 7'd0;
         last_in  = 1'b0;
         unique case (cmd.kind)
            CMD_CELL: begin
               ccol_in  = col_ff;
               crow_in  = row_ff;
               glyph_in = cell_glyph;
               fore_in  = fg_rgb;
            end
            CMD_SCROLL, CMD_FILL: ;
            CMD_DONE: begin
               back_in = 24'd0;
               racc_in = acc_ff;
               ncol_in = col_ff;
               nrow_in = row_ff;
               last_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff  <= ATTR_RESET;
         col_ff   <= 8'd0;
         row_ff   <= 7'd0;
         acc_ff   <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         attr_ff  <= attr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      char_ff  <= char_in;
      tcol_ff  <= tcol_in;
      trow_ff  <= trow_in;
      kind_ff  <= kind_in;
      ccol_ff  <= ccol_in;
      crow_ff  <= crow_in;
      glyph_ff <= glyph_in;
      fore_ff  <= fore_in;
      back_ff  <= back_in;
      racc_ff  <= racc_in;
      ncol_ff  <= ncol_in;
      nrow_ff  <= nrow_in;
      last_ff  <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_command        = kind_ff;
   assign rsp_cell_column    = ccol_ff;
   assign rsp_cell_row       = crow_ff;
   assign rsp_glyph          = glyph_ff;
   assign rsp_fore_color     = fore_ff;
   assign rsp_back_color     = back_ff;
   assign rsp_accepted       = racc_ff;
   assign rsp_cursor_col_now = ncol_ff;
   assign rsp_cursor_row_now = nrow_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== design/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps
// Teletype cursor engine for a text console.
// Request channel (req_valid / req_stall): one command word per request:
// put character, set cursor position or clear screen. Response channel
// (rsp_valid / rsp_stall): drawing words (draw cell, scroll, fill screen)
// followed by one done word with rsp_last set, carrying the cursor.
// csr_wr_en / csr_wr_data write the text attribute (fg bits 3:0, bg 6:4);
// write it only while no command is in flight.
// Each command passes a decode state, then sends its response words in turn
// through the single output register; a tab with a scroll is the longest
// case. The controller handles one command at a time; the next request
// is taken as soon as the done word is loaded into the output register.
// Reset (synchronous, active high): cursor at column 0 row 0, attribute
// 0x07, no response pending.
// When the receiver stalls, the output word holds and the controller
// waits in its emit state; req_stall stays high meanwhile.
module text_console_cursor_engine
   import tcce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_character,
   input  logic [7:0]  req_target_column,
   input  logic [6:0]  req_target_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_command,
   output logic [7:0]  rsp_cell_column,
   output logic [6:0]  rsp_cell_row,
   output logic [7:0]  rsp_glyph,
   output logic [23:0] rsp_fore_color,
   output logic [23:0] rsp_back_color,
   output logic        rsp_accepted,
   output logic [7:0]  rsp_cursor_col_now,
   output logic [6:0]  rsp_cursor_row_now,
   output logic        rsp_last
);

   tcce_cmd_type    cmd;
   tcce_status_type status;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_operation      (req_operation),
      .req_character      (req_character),
      .req_target_column  (req_target_column),
      .req_target_row     (req_target_row),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_command        (rsp_command),
      .rsp_cell_column    (rsp_cell_column),
      .rsp_cell_row       (rsp_cell_row),
      .rsp_glyph          (rsp_glyph),
      .rsp_fore_color     (rsp_fore_color),
      .rsp_back_color     (rsp_back_color),
      .rsp_accepted       (rsp_accepted),
      .rsp_cursor_col_now (rsp_cursor_col_now),
      .rsp_cursor_row_now (rsp_cursor_row_now),
      .rsp_last           (rsp_last)
   );

endmodule
